// File: rtl/assert_macros.svh
// Assertion macros used by the checker file sba_checker.
// Implication forms with an active-low reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication.
`define ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// File: rtl/sba_pkg.sv
// Package for the spectrum band averager: widths, constants, control structs.
// No dependencies.
`default_nettype none
package sba_pkg;
    localparam int EDGE_W = 26;
    localparam logic [25:0] EDGE_MAX = 26'h3FFFFFF;
    localparam logic [27:0] LOG_K_Q16 = 28'd268430242;

    // register indexes
    localparam logic [2:0] REG_START = 3'd0;
    localparam logic [2:0] REG_WIDTH = 3'd1;
    localparam logic [2:0] REG_CLIP = 3'd2;
    localparam logic [2:0] REG_BASE = 3'd3;
    localparam logic [2:0] REG_RSTART = 3'd4;
    localparam logic [2:0] REG_RSTEP = 3'd5;
    localparam logic [2:0] REG_RBANDS = 3'd6;
    localparam logic [2:0] REG_LOG = 3'd7;

    typedef struct packed {
        logic [25:0] start_edge;
        logic [25:0] band_width;
        logic [15:0] clip_offset;
        logic [23:0] base_gain;
        logic [23:0] ramp_start_gain;
        logic [23:0] ramp_step_gain;
        logic [6:0]  ramp_bands;
        logic        log_enable;
    } t_cfg;

    // controller -> datapath commands
    typedef struct packed {
        logic init;
        logic add;
        logic close_start;
        logic step_bin;
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic below_edge;
        logic bands_done;
        logic in_range;
        logic close_busy;
        logic bin_max;
    } t_sts;
endpackage
`default_nettype wire

// File: rtl/sba_if.sv
// Valid/ready stream interfaces for bin input and band output words.
// No dependencies.
`default_nettype none
interface sba_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] bin_value;
    logic        frame_last;
    modport source(output valid, bin_value, frame_last, input ready);
    modport sink(input valid, bin_value, frame_last, output ready);
endinterface

interface sba_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] band_value;
    logic [5:0]  band_number;
    logic        band_empty;
    logic        run_last;
    modport source(output valid, band_value, band_number, band_empty, run_last,
                   input ready);
    modport sink(input valid, band_value, band_number, band_empty, run_last,
                 output ready);
endinterface
`default_nettype wire

// File: rtl/spectrum_band_averager_core.sv
// Spectrum band averager: bins in, averaged gain-scaled band levels out.
// Each accepted bin is held until the bands it passes are closed in turn by the
// one-bit-per-cycle divider, gain and clamp stages (an empty band skips them) and,
// with the log map on, the squaring log unit; a stalled output word adds its wait.
// A frame end closes all remaining bands in turn.
// Depends on sba_pkg, sba_if, sba_ctrl and sba_dp.
`default_nettype none
module spectrum_band_averager_core #(
    parameter int NUM_BANDS = 32,
    parameter int MAX_BINS = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    sba_in_if.sink           in_if,
    sba_out_if.source        out_if
);
    import sba_pkg::*;

    t_cfg r_cfg;
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite;
    assign w_idx = paddr[4:2];

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_edge <= '0;
            r_cfg.band_width <= 26'd1048576;
            r_cfg.clip_offset <= '0;
            r_cfg.base_gain <= 24'd32768;
            r_cfg.ramp_start_gain <= 24'd32768;
            r_cfg.ramp_step_gain <= '0;
            r_cfg.ramp_bands <= '0;
            r_cfg.log_enable <= 1'b0;
        end else if (w_wr) begin
            case (w_idx)
                REG_START: r_cfg.start_edge <= pwdata[25:0];
                REG_WIDTH: r_cfg.band_width <= pwdata[25:0];
                REG_CLIP: r_cfg.clip_offset <= pwdata[15:0];
                REG_BASE: r_cfg.base_gain <= pwdata[23:0];
                REG_RSTART: r_cfg.ramp_start_gain <= pwdata[23:0];
                REG_RSTEP: r_cfg.ramp_step_gain <= pwdata[23:0];
                REG_RBANDS: r_cfg.ramp_bands <= pwdata[6:0];
                REG_LOG: r_cfg.log_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_START: prdata = {6'd0, r_cfg.start_edge};
            REG_WIDTH: prdata = {6'd0, r_cfg.band_width};
            REG_CLIP: prdata = {16'd0, r_cfg.clip_offset};
            REG_BASE: prdata = {8'd0, r_cfg.base_gain};
            REG_RSTART: prdata = {8'd0, r_cfg.ramp_start_gain};
            REG_RSTEP: prdata = {8'd0, r_cfg.ramp_step_gain};
            REG_RBANDS: prdata = {25'd0, r_cfg.ramp_bands};
            REG_LOG: prdata = {31'd0, r_cfg.log_enable};
            default: prdata = '0;
        endcase
    end

    // a register write lands next cycle; restart the frame from new values
    logic r_wr_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_wr_d <= 1'b0;
        else r_wr_d <= w_wr;
    end

    // hold the accepted bin
    logic [15:0] r_bin;
    always_ff @(posedge i_clk) begin
        if (in_if.valid && in_if.ready) begin
            r_bin <= in_if.bin_value;
        end
    end

    logic r_is_last;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_is_last <= 1'b0;
        else if (in_if.valid && in_if.ready) r_is_last <= in_if.frame_last || w_sts.bin_max;
    end

    sba_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_wr(r_wr_d),
        .i_in_valid(in_if.valid), .i_in_last(in_if.frame_last),
        .o_in_ready(in_if.ready), .i_sts(w_sts), .o_cmd(w_cmd)
    );

    sba_dp #(.NUM_BANDS(NUM_BANDS), .MAX_BINS(MAX_BINS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_cmd(w_cmd),
        .i_bin(r_bin), .i_is_last(r_is_last),
        .o_sts(w_sts), .out(out_if)
    );
endmodule
`default_nettype wire

// File: rtl/sba_ctrl.sv
// Controller state machine of the band averager.
// Depends on sba_pkg.
`default_nettype none
module sba_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_wr,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_last,
    output logic               o_in_ready,
    input  wire sba_pkg::t_sts i_sts,
    output sba_pkg::t_cmd      o_cmd
);
    import sba_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CLOSE = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0] r_state, n_state;
    logic r_last, n_last;

    // per-bin sequence: close bands below edge, add, flush at frame end
    always_comb begin
        n_state = r_state;
        n_last = r_last;
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = !i_sts.close_busy;
                if (i_in_valid && o_in_ready) begin
                    n_last = i_in_last || i_sts.bin_max;
                    n_state = S_CLOSE;
                end
            end
            S_CLOSE: begin
                if (!i_sts.close_busy) begin
                    if (!i_sts.bands_done && i_sts.below_edge) begin
                        o_cmd.close_start = 1'b1;
                    end else begin
                        o_cmd.add = i_sts.in_range;
                        n_state = r_last ? S_FLUSH : S_WAIT;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_sts.close_busy) begin
                    if (!i_sts.bands_done) begin
                        o_cmd.close_start = 1'b1;
                    end else begin
                        o_cmd.init = 1'b1;
                        n_state = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                o_cmd.step_bin = !r_last;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (i_cfg_wr) begin
            o_cmd.init = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last <= n_last;
        end
    end
endmodule
`default_nettype wire

// File: rtl/sba_dp.sv
// Datapath: bin accumulation, edge tracking, serial divider, gain, log map.
// Depends on sba_pkg and sba_if.
`default_nettype none
module sba_dp #(
    parameter int NUM_BANDS = 32,
    parameter int MAX_BINS = 1024
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sba_pkg::t_cfg i_cfg,
    input  wire sba_pkg::t_cmd i_cmd,
    input  wire logic [15:0]   i_bin,
    input  wire logic          i_is_last,
    output sba_pkg::t_sts      o_sts,
    sba_out_if.source          out
);
    import sba_pkg::*;

    localparam int BW = $clog2(MAX_BINS);
    localparam int NB = $clog2(NUM_BANDS + 1);

    logic [BW-1:0] r_bin;
    logic [NB-1:0] r_band;
    logic [25:0] r_edge, r_sum;
    logic [BW:0] r_cnt;
    logic [31:0] r_rgain;
    logic [26:0] w_esum;
    logic [25:0] w_next_edge;

    assign w_esum = {1'b0, r_edge} + {1'b0, i_cfg.band_width};
    assign w_next_edge = w_esum[26] ? EDGE_MAX : w_esum[25:0];

    // close pipeline registers
    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_DIV = 3'd1;
    localparam logic [2:0] P_MUL = 3'd2;
    localparam logic [2:0] P_SAT = 3'd3;
    localparam logic [2:0] P_LOG = 3'd4;
    localparam logic [2:0] P_LMUL = 3'd5;
    localparam logic [2:0] P_OUT = 3'd6;
    logic [2:0] r_ps;
    logic [25:0] r_num, r_q;
    logic [BW:0] r_den;
    logic [26:0] r_rem;
    logic [4:0] r_k;
    logic [31:0] r_gain;
    logic [15:0] r_clip;
    logic r_empty, r_log;
    logic [5:0] r_bnum;
    logic [47:0] r_prod;
    logic [15:0] r_val;
    logic [3:0] r_n;
    logic [31:0] r_m;
    logic [19:0] r_frac;
    logic [51:0] r_lp;
    logic r_rl;

    logic [26:0] w_rem_sh;
    logic [63:0] w_sq;
    logic [32:0] w_m2;
    logic [15:0] w_x;
    logic [3:0] w_n;
    logic [15:0] w_diff;
    logic [23:0] w_l;

    assign w_rem_sh = {r_rem[25:0], r_num[25]};
    assign w_sq = {32'd0, r_m} * {32'd0, r_m};
    assign w_m2 = w_sq[62:30];
    assign w_x = (r_val == 16'd0) ? 16'd1 : r_val;
    assign w_diff = r_q[15:0] - r_clip;
    assign w_l = {r_n, r_frac};

    always_comb begin
        w_n = 4'd0;
        for (int b = 1; b < 16; b++) begin
            if (w_x[b]) w_n = 4'(b);
        end
    end

    assign o_sts.close_busy = (r_ps != P_IDLE);
    assign o_sts.bands_done = (32'(r_band) >= NUM_BANDS);
    assign o_sts.below_edge = (32'(r_bin) >= 32'(r_edge[25:16]));
    assign o_sts.in_range = !o_sts.bands_done &&
        ((r_band != '0) || (32'(r_bin) >= 32'(i_cfg.start_edge[25:16])));
    assign o_sts.bin_max = (32'(r_bin) >= MAX_BINS - 1);

    // r_k = 31 marks the cycle that loads the log level into r_val
    assign out.valid = (r_ps == P_OUT) && (r_k != 5'd31);
    assign out.band_value = r_val;
    assign out.band_number = r_bnum;
    assign out.band_empty = r_empty;
    assign out.run_last = r_rl;

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.init) begin
            r_bin <= '0;
            r_band <= '0;
            r_sum <= '0;
            r_cnt <= '0;
            r_rgain <= {8'd0, i_cfg.ramp_start_gain};
            if (!i_rst_n) r_edge <= 26'd1048576;
            else begin
                r_edge <= ({1'b0, i_cfg.start_edge} + {1'b0, i_cfg.band_width} > 27'(EDGE_MAX))
                    ? EDGE_MAX : i_cfg.start_edge + i_cfg.band_width;
            end
        end else begin
            if (i_cmd.step_bin) r_bin <= r_bin + 1'b1;
            if (i_cmd.add) begin
                r_sum <= r_sum + {10'd0, i_bin};
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.close_start) begin
                r_band <= r_band + 1'b1;
                r_edge <= w_next_edge;
                r_sum <= '0;
                r_cnt <= '0;
                r_rgain <= r_rgain + {8'd0, i_cfg.ramp_step_gain};
            end
        end
    end

    // band close engine: restoring divide, gain, clamp, log2 by squaring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps <= P_IDLE;
        end else begin
            case (r_ps)
                P_IDLE: begin
                    if (i_cmd.close_start) begin
                        r_num <= r_sum;
                        r_den <= r_cnt;
                        r_rem <= '0;
                        r_q <= '0;
                        r_k <= 5'd0;
                        r_gain <= (7'(r_band) < i_cfg.ramp_bands) ? r_rgain
                                                                  : {8'd0, i_cfg.base_gain};
                        r_clip <= i_cfg.clip_offset;
                        r_empty <= (r_cnt == '0);
                        r_log <= i_cfg.log_enable;
                        r_bnum <= 6'(r_band);
                        // last word of this bin: frame end flushes to the final band,
                        // otherwise no further band closes on this bin
                        r_rl <= i_is_last ? (32'(r_band) == NUM_BANDS - 1)
                                          : ((32'(r_band) >= NUM_BANDS - 1) ||
                                             (32'(r_bin) < 32'(w_next_edge[25:16])));
                        r_ps <= (r_cnt == '0) ? P_OUT : P_DIV;
                        r_val <= '0;
                    end
                end
                P_DIV: begin
                    if (w_rem_sh >= 27'(r_den)) begin
                        r_rem <= w_rem_sh - 27'(r_den);
                        r_q <= {r_q[24:0], 1'b1};
                    end else begin
                        r_rem <= w_rem_sh;
                        r_q <= {r_q[24:0], 1'b0};
                    end
                    r_num <= {r_num[24:0], 1'b0};
                    r_k <= r_k + 1'b1;
                    if (r_k == 5'd25) r_ps <= P_MUL;
                end
                P_MUL: begin
                    r_prod <= (r_q[15:0] > r_clip) ? ({32'd0, w_diff} * {16'd0, r_gain}) : '0;
                    r_ps <= P_SAT;
                end
                P_SAT: begin
                    r_val <= (r_prod[47:15] > 33'hFFFF) ? 16'hFFFF : r_prod[30:15];
                    r_ps <= r_log ? P_LOG : P_OUT;
                    r_k <= 5'd0;
                end
                P_LOG: begin
                    if (r_k == 5'd0) begin
                        r_n <= w_n;
                        r_m <= 32'({16'd0, w_x} << (5'd30 - {1'b0, w_n}));
                        r_frac <= '0;
                        r_k <= 5'd1;
                    end else begin
                        if (w_m2[32:31] != 2'd0) begin
                            r_m <= w_m2[32:1];
                            r_frac <= {r_frac[18:0], 1'b1};
                        end else begin
                            r_m <= w_m2[31:0];
                            r_frac <= {r_frac[18:0], 1'b0};
                        end
                        r_k <= r_k + 1'b1;
                        if (r_k == 5'd20) r_ps <= P_LMUL;
                    end
                end
                P_LMUL: begin
                    r_lp <= {28'd0, w_l} * {24'd0, LOG_K_Q16};
                    r_ps <= P_OUT;
                    r_k <= 5'd31;
                end
                P_OUT: begin
                    // product stays below 2^52, so bits 51:36 never overflow
                    if (r_k == 5'd31) begin
                        r_val <= r_lp[51:36];
                        r_k <= 5'd0;
                    end else if (out.ready) begin
                        r_ps <= P_IDLE;
                    end
                end
                default: r_ps <= P_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/sba_checker.sv
// Port-level checker for the band averager, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module sba_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] band_value,
    input wire logic        band_empty
);
    // an empty band reports zero
    `ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, out_valid && band_empty, band_value == 16'd0)
    // a stalled word stays valid
    `ASSERT_NXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid)
    // no new bin is taken while a band word is on offer
    `ASSERT_IMP(a_excl, i_clk, i_rst_n, out_valid, !in_ready)
endmodule

bind spectrum_band_averager_core sba_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_valid(in_if.valid), .in_ready(in_if.ready),
    .out_valid(out_if.valid), .out_ready(out_if.ready),
    .band_value(out_if.band_value), .band_empty(out_if.band_empty)
);
`default_nettype wire

// File: verif/sba_band_checker.sv
// Band checker: watches the config port and both streams, predicts each band word.
// Depends on sba_pkg and the stream interfaces in sba_if.
`timescale 1ns / 100ps
module sba_band_checker
    import sba_pkg::*;
#(
    parameter int NUM_BANDS = 32,
    parameter int MAX_BINS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    sba_in_if           in_if,
    sba_out_if          out_if,
    output int          o_fail_count,
    output int          o_pending
);
    typedef struct {
        logic [15:0] value;
        logic [5:0]  number;
        logic        empty;
        logic        last;
    } band_word_t;

    band_word_t  expected_bands[$];
    t_cfg        cfg;
    int unsigned bin_idx, band_idx, edge_acc, bin_sum, bin_cnt, band_gain;

    assign o_pending = expected_bands.size();

    function automatic int unsigned sat_edge(int unsigned a, int unsigned b);
        logic [31:0] s;
        s = a + b;
        return (s > EDGE_MAX) ? EDGE_MAX : s;
    endfunction

    function automatic logic [15:0] log_level(int unsigned x);
        int unsigned n;
        int unsigned frac;
        logic [63:0] m;
        logic [63:0] res;
        n = 0;
        frac = 0;
        if (x == 0) x = 1;
        while (n < 15 && (x >> (n + 1)) != 0) n++;
        // normalize to Q30 in [1,2), then one fraction bit per squaring
        m = 64'(x) << (30 - n);
        for (int k = 0; k < 20; k++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        res = ((64'(n) << 20) | 64'(frac)) * 64'(LOG_K_Q16);
        res = res >> 36;
        return (res > 64'hFFFF) ? 16'hFFFF : res[15:0];
    endfunction

    task automatic restart_frame();
        bin_idx   = 0;
        band_idx  = 0;
        edge_acc  = sat_edge(cfg.start_edge, cfg.band_width);
        bin_sum   = 0;
        bin_cnt   = 0;
        band_gain = cfg.ramp_start_gain;
    endtask

    task automatic close_band();
        band_word_t  w;
        int unsigned avg;
        int unsigned gain;
        logic [63:0] p;
        w.value = 0;
        w.empty = 1;
        w.last  = 0;
        if (bin_cnt != 0) begin
            avg  = bin_sum / bin_cnt;
            gain = (band_idx < cfg.ramp_bands) ? band_gain : cfg.base_gain;
            w.empty = 0;
            if (avg > cfg.clip_offset) begin
                p = (64'(avg - cfg.clip_offset) * 64'(gain)) >> 15;
                w.value = (p > 64'hFFFF) ? 16'hFFFF : p[15:0];
            end
            if (cfg.log_enable) w.value = log_level(w.value);
        end
        w.number = band_idx[5:0];
        expected_bands.push_back(w);
        band_idx++;
        edge_acc  = sat_edge(edge_acc, cfg.band_width);
        bin_sum   = 0;
        bin_cnt   = 0;
        band_gain = band_gain + cfg.ramp_step_gain;
    endtask

    // one accepted bin: close passed bands, add, flush on frame end
    task automatic take_bin(logic [15:0] v, logic frame_last);
        int unsigned n;
        logic        at_end;
        band_word_t  w;
        n = 0;
        at_end = frame_last || (bin_idx >= MAX_BINS - 1);
        while (band_idx < NUM_BANDS && bin_idx >= (edge_acc >> 16)) begin
            close_band();
            n++;
        end
        if (band_idx < NUM_BANDS && (band_idx != 0 || bin_idx >= (cfg.start_edge >> 16)))
        begin
            bin_sum += v;
            bin_cnt++;
        end
        if (at_end) begin
            while (band_idx < NUM_BANDS) begin
                close_band();
                n++;
            end
            restart_frame();
        end else begin
            bin_idx++;
        end
        if (n > 0) begin
            w = expected_bands.pop_back();
            w.last = 1;
            expected_bands.push_back(w);
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_START:  cfg.start_edge      = val[25:0];
            REG_WIDTH:  cfg.band_width      = val[25:0];
            REG_CLIP:   cfg.clip_offset     = val[15:0];
            REG_BASE:   cfg.base_gain       = val[23:0];
            REG_RSTART: cfg.ramp_start_gain = val[23:0];
            REG_RSTEP:  cfg.ramp_step_gain  = val[23:0];
            REG_RBANDS: cfg.ramp_bands      = val[6:0];
            REG_LOG:    cfg.log_enable      = val[0];
            default: ;
        endcase
        restart_frame();
    endtask

    task automatic report(string what, band_word_t exp_w);
        if (o_fail_count < 10) begin
            $write("%0t band mismatch (%s): exp val=%0d num=%0d empty=%0d last=%0d, ",
                   $realtime, what, exp_w.value, exp_w.number, exp_w.empty, exp_w.last);
            $display("got val=%0d num=%0d empty=%0d last=%0d",
                     out_if.band_value, out_if.band_number, out_if.band_empty,
                     out_if.run_last);
        end
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        cfg = '{start_edge: 26'd0, band_width: 26'd1048576, clip_offset: 16'd0,
                base_gain: 24'd32768, ramp_start_gain: 24'd32768,
                ramp_step_gain: 24'd0, ramp_bands: 7'd0, log_enable: 1'b0};
        restart_frame();
    end

    // sample at the edge; the bench drives with nonblocking updates
    always @(posedge i_clk) begin
        band_word_t exp_w;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (expected_bands.size() == 0) begin
                    exp_w = '{value: 0, number: 0, empty: 0, last: 0};
                    report("no word expected", exp_w);
                end else begin
                    exp_w = expected_bands.pop_front();
                    if (out_if.band_value !== exp_w.value ||
                        out_if.band_number !== exp_w.number ||
                        out_if.band_empty !== exp_w.empty ||
                        out_if.run_last !== exp_w.last)
                        report("field", exp_w);
                end
            end
            if (in_if.valid && in_if.ready) take_bin(in_if.bin_value, in_if.frame_last);
            if (i_psel && i_penable && i_pwrite && i_pready) write_reg(i_paddr[4:2], i_pwdata);
        end
    end
endmodule

// File: verif/spectrum_band_averager_core_tb.sv
// Top of the band averager bench: clock, reset, config writes, bin stimulus, verdict.
// Depends on sba_pkg, sba_if, the core and sba_band_checker.
`timescale 1ns / 100ps
module spectrum_band_averager_core_tb;
    import sba_pkg::*;

    localparam int CYCLE_LIMIT = 20000000;
    localparam int DRAIN_CYCLES = 200;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending;
    int          cycle_count;
    int          rand_items;
    int          out_wait;
    logic        no_idle;

    sba_in_if  in_if();
    sba_out_if out_if();

    spectrum_band_averager_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_if(in_if), .out_if(out_if)
    );

    sba_band_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .in_if(in_if), .out_if(out_if),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 17);
    endfunction

    // run-away guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** spectrum_band_averager_core: FAILED **");
            $finish;
        end
    end

    // receiver: random stall after each accepted word
    always @(posedge i_clk) begin
        int w;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                w = draw_gap();
                out_wait <= w;
                out_if.ready <= (w == 0);
            end else if (out_wait > 1) begin
                out_wait <= out_wait - 1;
            end else if (out_wait == 1) begin
                out_wait <= 0;
                out_if.ready <= 1'b1;
            end
        end
    end

    task automatic set_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // valid stays high across back-to-back words
    task automatic send_bin(logic [15:0] v, logic frame_last);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.bin_value <= v;
        in_if.frame_last <= frame_last;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    task automatic send_frame(int nbins);
        for (int k = 0; k < nbins; k++)
            send_bin(16'($urandom()), k == nbins - 1);
    endtask

    // quiet the block before touching registers
    task automatic drain();
        @(posedge i_clk);
        in_if.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_all(logic [25:0] st, logic [25:0] bw, logic [15:0] clip,
                           logic [23:0] base, logic [23:0] rst, logic [23:0] rstep,
                           logic [6:0] rb, logic lg);
        set_reg(REG_START, {6'd0, st});
        set_reg(REG_WIDTH, {6'd0, bw});
        set_reg(REG_CLIP, {16'd0, clip});
        set_reg(REG_BASE, {8'd0, base});
        set_reg(REG_RSTART, {8'd0, rst});
        set_reg(REG_RSTEP, {8'd0, rstep});
        set_reg(REG_RBANDS, {25'd0, rb});
        set_reg(REG_LOG, {31'd0, lg});
    endtask

    task automatic random_config();
        logic [25:0] st, bw;
        st = ($urandom_range(0, 7) == 0) ? 26'h2000000 : 26'($urandom_range(0, 3 << 16));
        case ($urandom_range(0, 7))
            0:       bw = 26'd0;
            1:       bw = 26'h2000000;
            default: bw = 26'($urandom_range(16'h4000, 3 << 16));
        endcase
        set_all(st, bw, ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 300)),
                ($urandom_range(0, 5) == 0) ? 24'hFFFFFF : 24'($urandom()),
                24'($urandom()), 24'($urandom_range(0, 4095)),
                7'($urandom_range(0, 64)), 1'($urandom()));
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_if.valid = 1'b0;
        in_if.bin_value = '0;
        in_if.frame_last = 1'b0;
        out_if.ready = 1'b1;
        out_wait = 0;
        cycle_count = 0;
        no_idle = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // defaults: 16-bin bands, extremes of the bin value
        send_bin(16'h0000, 1'b0);
        send_bin(16'hFFFF, 1'b0);
        for (int k = 0; k < 15; k++) send_bin(16'hFFFF, 1'b0);
        send_bin(16'h1234, 1'b1);
        drain();

        // half-bin bands leave empty ones; big clip makes every level zero
        set_all(26'h18000, 26'h8000, 16'hFFFF, 24'h8000, 24'h8000, 24'd0, 7'd0, 1'b0);
        send_frame(4);
        drain();

        // ramped gain, log map on, zero and max levels
        set_all(26'h0, 26'h10000, 16'd0, 24'hFFFFFF, 24'd0, 24'h1000, 7'd64, 1'b1);
        send_bin(16'h0000, 1'b0);
        send_bin(16'hFFFF, 1'b0);
        send_bin(16'h0001, 1'b1);
        drain();

        // edges saturate; every bin below the first edge is ignored
        set_all(26'h2000000, 26'h2000000, 16'd0, 24'h8000, 24'h8000, 24'd0, 7'd3, 1'b0);
        send_frame(3);
        drain();

        // zero width: one bin closes every band at once
        set_reg(REG_WIDTH, 32'd0);
        set_reg(REG_START, 32'h20000);
        send_frame(4);
        drain();

        // back-to-back run with no frame_last
        no_idle = 1'b1;
        set_all(26'h0, 26'h20000, 16'd10, 24'h8000, 24'h4000, 24'h800, 7'd5, 1'b0);
        for (int k = 0; k < 40; k++) send_bin(16'($urandom()), 1'b0);
        drain();
        no_idle = 1'b0;

        // random phases: fresh settings, then frames of random bins
        rand_items = 0;
        while (rand_items < 80) begin
            int nframes;
            random_config();
            no_idle = ($urandom_range(0, 3) == 0);
            nframes = $urandom_range(1, 3);
            for (int f = 0; f < nframes; f++) begin
                int nb;
                nb = $urandom_range(1, 40);
                if ($urandom_range(0, 4) == 0) begin
                    // stray frame_last marks inside the run
                    for (int k = 0; k < nb; k++)
                        send_bin(16'($urandom()), $urandom_range(0, 7) == 0);
                end else begin
                    send_frame(nb);
                end
                rand_items += nb;
            end
            drain();
            no_idle = 1'b0;
        end

        // restore the reset settings once more before the end
        set_all(26'd0, 26'd1048576, 16'd0, 24'd32768, 24'd32768, 24'd0, 7'd0, 1'b0);
        send_frame(20);
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("** spectrum_band_averager_core: PASSED **");
        end else begin
            $display("** spectrum_band_averager_core: FAILED **");
        end
        $finish;
    end
endmodule
